// ----- rtl/core/mtbt_pkg.sv -----
// ----------------------------------------------------------------------------
// Multi-terminal bus target package
// Shared constants, codes and types for the terminal bus target.
// ----------------------------------------------------------------------------
package mtbt_pkg;

  localparam int unsigned MAX_TERMINALS = 16;
  localparam int unsigned NUM_SLOTS     = 16;

  localparam logic [3:0] REG_MASK      = 4'hC;
  localparam logic [3:0] WRITE_OFFSET  = 4'h0;
  localparam logic [3:0] STATUS_OFFSET = 4'h4;
  localparam logic [3:0] READ_OFFSET   = 4'h8;
  localparam logic [3:0] CONFIG_OFFSET = 4'hC;

  localparam logic [7:0] CHAR_CR = 8'h0d;

  localparam logic [31:0] SEG_BASE_RST   = 32'h0000_0000;
  localparam logic [31:0] SEG_SIZE_RST   = 32'h0000_0100;
  localparam logic [4:0]  TERM_COUNT_RST = 5'd16;
  localparam logic [15:0] KBD_IRQ_EN_RST = 16'hFFFF;
  localparam logic [15:0] DSP_IRQ_EN_RST = 16'h0000;

  typedef enum logic [1:0] {
    ACK_NONE  = 2'd0,
    ACK_READY = 2'd1,
    ACK_ERROR = 2'd2
  } ack_e;

  typedef enum logic [2:0] {
    CFG_SEG_BASE   = 3'd0,
    CFG_SEG_SIZE   = 3'd1,
    CFG_TERM_COUNT = 3'd2,
    CFG_KBD_IRQ_EN = 3'd3,
    CFG_DSP_IRQ_EN = 3'd4
  } cfg_reg_e;

  // Decoded bus access for the item in the input register
  typedef struct packed {
    ack_e       ack;
    logic       data_write;
    logic       status_read;
    logic       data_read;
    logic [3:0] term;
  } dec_t;

endpackage

// ----- rtl/core/mtbt_if.sv -----
// ----------------------------------------------------------------------------
// Terminal bus target channels
// Valid/ready channels carrying input items and result items.
// ----------------------------------------------------------------------------
interface mtbt_in_if;
  logic        valid;
  logic        ready;
  logic        bus_select;
  logic [31:0] address;
  logic        is_read;
  logic [31:0] write_data;
  logic        key_valid;
  logic [3:0]  key_terminal;
  logic [7:0]  key_char;

  modport source (
    output valid, bus_select, address, is_read, write_data, key_valid, key_terminal,
           key_char,
    input  ready
  );
  modport sink (
    input  valid, bus_select, address, is_read, write_data, key_valid, key_terminal,
           key_char,
    output ready
  );
endinterface

interface mtbt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  ack;
  logic [7:0]  read_data;
  logic        display_valid;
  logic [3:0]  display_terminal;
  logic [7:0]  display_char;
  logic        key_taken;
  logic [15:0] irq_keyboard;
  logic [15:0] irq_display;

  modport source (
    output valid, ack, read_data, display_valid, display_terminal, display_char,
           key_taken, irq_keyboard, irq_display,
    input  ready
  );
  modport sink (
    input  valid, ack, read_data, display_valid, display_terminal, display_char,
           key_taken, irq_keyboard, irq_display,
    output ready
  );
endinterface

// ----- rtl/core/mtbt_decode.sv -----
// ----------------------------------------------------------------------------
// Bus access decoder
// Segment check, terminal select and register select for one bus access.
// ----------------------------------------------------------------------------
module mtbt_decode (
  input  logic            bus_select_i,
  input  logic [31:0]     address_i,
  input  logic            is_read_i,
  input  logic [31:0]     seg_base_i,
  input  logic [31:0]     seg_size_i,
  input  logic [4:0]      term_count_i,
  output mtbt_pkg::dec_t  dec_o,
  output logic [15:0]     term_mask_o
);

  logic [32:0] seg_end;
  logic        in_seg;
  logic [3:0]  term;
  logic [3:0]  reg_sel;

  // Terminals in use: below both the programmed count and the build limit
  always_comb begin
    for (int i = 0; i < mtbt_pkg::NUM_SLOTS; i++) begin
      term_mask_o[i] = (5'(i) < term_count_i) && (i < mtbt_pkg::MAX_TERMINALS);
    end
  end

  assign seg_end = {1'b0, seg_base_i} + {1'b0, seg_size_i};
  assign in_seg  = (address_i >= seg_base_i) && ({1'b0, address_i} < seg_end);
  assign term    = address_i[7:4];
  assign reg_sel = address_i[3:0] & mtbt_pkg::REG_MASK;

  always_comb begin
    dec_o             = '0;
    dec_o.ack         = mtbt_pkg::ACK_NONE;
    dec_o.term        = term;
    if (bus_select_i) begin
      if (!in_seg || !term_mask_o[term]) begin
        dec_o.ack = mtbt_pkg::ACK_ERROR;
      end else if (reg_sel == mtbt_pkg::WRITE_OFFSET && !is_read_i) begin
        dec_o.ack        = mtbt_pkg::ACK_READY;
        dec_o.data_write = 1'b1;
      end else if (reg_sel == mtbt_pkg::STATUS_OFFSET && is_read_i) begin
        dec_o.ack         = mtbt_pkg::ACK_READY;
        dec_o.status_read = 1'b1;
      end else if (reg_sel == mtbt_pkg::READ_OFFSET && is_read_i) begin
        dec_o.ack       = mtbt_pkg::ACK_READY;
        dec_o.data_read = 1'b1;
      end else if (reg_sel == mtbt_pkg::CONFIG_OFFSET && !is_read_i) begin
        dec_o.ack = mtbt_pkg::ACK_READY;
      end else begin
        dec_o.ack = mtbt_pkg::ACK_ERROR;
      end
    end
  end

endmodule

// ----- rtl/core/mtbt_kbd.sv -----
// ----------------------------------------------------------------------------
// Keyboard buffers
// One-character buffer and full flag per terminal, key intake, read data
// and keyboard interrupt lines.
// ----------------------------------------------------------------------------
module mtbt_kbd (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            advance_i,
  input  mtbt_pkg::dec_t  dec_i,
  input  logic            key_valid_i,
  input  logic [3:0]      key_terminal_i,
  input  logic [7:0]      key_char_i,
  input  logic [15:0]     term_mask_i,
  input  logic [15:0]     kbd_irq_en_i,
  output logic [7:0]      read_data_o,
  output logic            key_taken_o,
  output logic [15:0]     irq_keyboard_o
);

  logic [15:0] full_q;
  logic [15:0] full_d;
  logic [7:0]  char_q [mtbt_pkg::NUM_SLOTS];
  logic        store;

  // A data read in the same item blocks intake on every terminal
  assign key_taken_o = key_valid_i && term_mask_i[key_terminal_i] &&
                       !full_q[key_terminal_i] && !dec_i.data_read;
  assign store       = key_taken_o && (key_char_i != mtbt_pkg::CHAR_CR);

  always_comb begin
    full_d = full_q;
    if (dec_i.data_read) begin
      full_d[dec_i.term] = 1'b0;
    end
    if (store) begin
      full_d[key_terminal_i] = 1'b1;
    end
  end

  always_comb begin
    read_data_o = '0;
    if (dec_i.data_read) begin
      read_data_o = char_q[dec_i.term];
    end else if (dec_i.status_read) begin
      read_data_o = {7'd0, full_d[dec_i.term]};
    end
  end

  assign irq_keyboard_o = full_d & kbd_irq_en_i & term_mask_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= '0;
      for (int i = 0; i < mtbt_pkg::NUM_SLOTS; i++) begin
        char_q[i] <= '0;
      end
    end else if (advance_i) begin
      full_q <= full_d;
      if (store) begin
        char_q[key_terminal_i] <= key_char_i;
      end
    end
  end

endmodule

// ----- rtl/core/multi_terminal_bus_target.sv -----
// ----------------------------------------------------------------------------
// Multi-terminal bus target
// Memory-mapped controller for up to sixteen character terminals.
// ----------------------------------------------------------------------------
// Each item carries one bus access and an optional keyboard character. An
// accepted item waits in an input register, is decoded and applied to the
// keyboard buffers, and its result lands in a result register when the item
// advances, which it does once the result register is empty or being read.
// One item is accepted every cycle as long as results are drained; the pace
// is set by the update of the per-terminal full flags, which each item reads
// and writes. The user must write configuration through the APB port only
// while no item is in flight; the block does not enforce this. Registers sit
// at byte offsets 0x00 (segment base), 0x04 (segment size), 0x08 (terminal
// count), 0x0C (keyboard irq enable) and 0x10 (display irq enable).
module multi_terminal_bus_target (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  mtbt_in_if.sink      in_i,
  mtbt_out_if.source   out_o
);

  // Configuration registers
  logic [31:0] seg_base_q;
  logic [31:0] seg_size_q;
  logic [4:0]  term_count_q;
  logic [15:0] kbd_irq_en_q;
  logic [15:0] dsp_irq_en_q;
  logic        cfg_we;
  mtbt_pkg::cfg_reg_e cfg_sel;

  // Input register
  logic        in_valid_q;
  logic        bus_select_q;
  logic [31:0] address_q;
  logic        is_read_q;
  logic [31:0] write_data_q;
  logic        key_valid_q;
  logic [3:0]  key_terminal_q;
  logic [7:0]  key_char_q;
  logic        load;
  logic        advance;

  // Result register
  logic            out_valid_q;
  mtbt_pkg::ack_e  ack_q;
  logic [7:0]      read_data_q;
  logic            display_valid_q;
  logic [3:0]      display_terminal_q;
  logic [7:0]      display_char_q;
  logic            key_taken_q;
  logic [15:0]     irq_keyboard_q;
  logic [15:0]     irq_display_q;

  mtbt_pkg::dec_t dec;
  logic [15:0]    term_mask;
  logic [7:0]     read_data;
  logic           key_taken;
  logic [15:0]    irq_keyboard;

  // --------------------------------------------------------------------------
  // Configuration port
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign cfg_sel = mtbt_pkg::cfg_reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seg_base_q   <= mtbt_pkg::SEG_BASE_RST;
      seg_size_q   <= mtbt_pkg::SEG_SIZE_RST;
      term_count_q <= mtbt_pkg::TERM_COUNT_RST;
      kbd_irq_en_q <= mtbt_pkg::KBD_IRQ_EN_RST;
      dsp_irq_en_q <= mtbt_pkg::DSP_IRQ_EN_RST;
    end else if (cfg_we) begin
      case (cfg_sel)
        mtbt_pkg::CFG_SEG_BASE:   seg_base_q   <= pwdata;
        mtbt_pkg::CFG_SEG_SIZE:   seg_size_q   <= pwdata;
        mtbt_pkg::CFG_TERM_COUNT: term_count_q <= pwdata[4:0];
        mtbt_pkg::CFG_KBD_IRQ_EN: kbd_irq_en_q <= pwdata[15:0];
        mtbt_pkg::CFG_DSP_IRQ_EN: dsp_irq_en_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_sel)
      mtbt_pkg::CFG_SEG_BASE:   prdata = seg_base_q;
      mtbt_pkg::CFG_SEG_SIZE:   prdata = seg_size_q;
      mtbt_pkg::CFG_TERM_COUNT: prdata = {27'd0, term_count_q};
      mtbt_pkg::CFG_KBD_IRQ_EN: prdata = {16'd0, kbd_irq_en_q};
      mtbt_pkg::CFG_DSP_IRQ_EN: prdata = {16'd0, dsp_irq_en_q};
      default:                  prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Handshake: advance the held item whenever the result register frees up
  assign advance    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || advance;
  assign load       = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      bus_select_q   <= in_i.bus_select;
      address_q      <= in_i.address;
      is_read_q      <= in_i.is_read;
      write_data_q   <= in_i.write_data;
      key_valid_q    <= in_i.key_valid;
      key_terminal_q <= in_i.key_terminal;
      key_char_q     <= in_i.key_char;
    end
  end

  // --------------------------------------------------------------------------
  mtbt_decode u_decode (
    .bus_select_i (bus_select_q),
    .address_i    (address_q),
    .is_read_i    (is_read_q),
    .seg_base_i   (seg_base_q),
    .seg_size_i   (seg_size_q),
    .term_count_i (term_count_q),
    .dec_o        (dec),
    .term_mask_o  (term_mask)
  );

  mtbt_kbd u_kbd (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .advance_i      (advance),
    .dec_i          (dec),
    .key_valid_i    (key_valid_q),
    .key_terminal_i (key_terminal_q),
    .key_char_i     (key_char_q),
    .term_mask_i    (term_mask),
    .kbd_irq_en_i   (kbd_irq_en_q),
    .read_data_o    (read_data),
    .key_taken_o    (key_taken),
    .irq_keyboard_o (irq_keyboard)
  );

  // --------------------------------------------------------------------------
  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ack_q              <= dec.ack;
      read_data_q        <= read_data;
      display_valid_q    <= dec.data_write;
      display_terminal_q <= dec.data_write ? dec.term : 4'd0;
      display_char_q     <= dec.data_write ? write_data_q[7:0] : 8'd0;
      key_taken_q        <= key_taken;
      irq_keyboard_q     <= irq_keyboard;
      irq_display_q      <= dsp_irq_en_q & term_mask;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.ack              = ack_q;
  assign out_o.read_data        = read_data_q;
  assign out_o.display_valid    = display_valid_q;
  assign out_o.display_terminal = display_terminal_q;
  assign out_o.display_char     = display_char_q;
  assign out_o.key_taken        = key_taken_q;
  assign out_o.irq_keyboard     = irq_keyboard_q;
  assign out_o.irq_display      = irq_display_q;

  // --------------------------------------------------------------------------
  // Assertions
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |=> in_valid_q && $stable(address_q) && $stable(key_char_q))
    else $error("held item lost or changed in the input register");

  a_display_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.display_valid |-> out_o.ack == mtbt_pkg::ACK_READY)
    else $error("display character without a ready response");

  a_irq_in_use: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> ((out_o.irq_keyboard | out_o.irq_display) & ~$past(term_mask)) == 16'd0)
    else $error("interrupt raised for a terminal not in use");

  a_no_take_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && dec.data_read |=> !out_o.key_taken)
    else $error("key taken during a data read");

endmodule

// ----- tb/multi_terminal_bus_target_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multi-terminal bus target testbench
// Drives bus accesses and keyboard characters through the input channel,
// reprograms the segment, terminal count and irq enables over APB between
// phases, and checks every result item against an internal model of the
// keyboard buffers and the address decode.
// ----------------------------------------------------------------------------
module multi_terminal_bus_target_tb;

  localparam int unsigned HALF_PERIOD = 6;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned HOLD_CYCLES = 300;

  typedef struct packed {
    logic        bus_select;
    logic [31:0] address;
    logic        is_read;
    logic [31:0] write_data;
    logic        key_valid;
    logic [3:0]  key_terminal;
    logic [7:0]  key_char;
  } bus_item_t;

  typedef struct packed {
    mtbt_pkg::ack_e ack;
    logic [7:0]     read_data;
    logic           display_valid;
    logic [3:0]     display_terminal;
    logic [7:0]     display_char;
    logic           key_taken;
    logic [15:0]    irq_keyboard;
    logic [15:0]    irq_display;
  } bus_result_t;

  // Terminal model: configuration, keyboard buffers and pending responses
  class term_scoreboard;
    logic [31:0]  seg_base;
    logic [31:0]  seg_size;
    logic [4:0]   term_count;
    logic [15:0]  kbd_irq_en;
    logic [15:0]  dsp_irq_en;
    bit           kbd_full [mtbt_pkg::NUM_SLOTS];
    logic [7:0]   kbd_char [mtbt_pkg::NUM_SLOTS];
    bus_result_t  response_q [$];
    int unsigned  mismatches;

    function new();
      seg_base   = mtbt_pkg::SEG_BASE_RST;
      seg_size   = mtbt_pkg::SEG_SIZE_RST;
      term_count = mtbt_pkg::TERM_COUNT_RST;
      kbd_irq_en = mtbt_pkg::KBD_IRQ_EN_RST;
      dsp_irq_en = mtbt_pkg::DSP_IRQ_EN_RST;
      foreach (kbd_full[i]) begin
        kbd_full[i] = 1'b0;
        kbd_char[i] = 8'h00;
      end
      mismatches = 0;
    endfunction

    function int unsigned terms_used();
      return (term_count > mtbt_pkg::MAX_TERMINALS) ? mtbt_pkg::MAX_TERMINALS
                                                     : int'(term_count);
    endfunction

    function void write_reg(mtbt_pkg::cfg_reg_e r, logic [31:0] v);
      case (r)
        mtbt_pkg::CFG_SEG_BASE:   seg_base   = v;
        mtbt_pkg::CFG_SEG_SIZE:   seg_size   = v;
        mtbt_pkg::CFG_TERM_COUNT: term_count = v[4:0];
        mtbt_pkg::CFG_KBD_IRQ_EN: kbd_irq_en = v[15:0];
        mtbt_pkg::CFG_DSP_IRQ_EN: dsp_irq_en = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [31:0] reg_value(mtbt_pkg::cfg_reg_e r);
      case (r)
        mtbt_pkg::CFG_SEG_BASE:   return seg_base;
        mtbt_pkg::CFG_SEG_SIZE:   return seg_size;
        mtbt_pkg::CFG_TERM_COUNT: return {27'b0, term_count};
        mtbt_pkg::CFG_KBD_IRQ_EN: return {16'b0, kbd_irq_en};
        mtbt_pkg::CFG_DSP_IRQ_EN: return {16'b0, dsp_irq_en};
        default:                  return 32'h0;
      endcase
    endfunction

    // Apply one bus cycle plus key offer and return the response it gives
    function bus_result_t decode_access(bus_item_t it);
      bus_result_t r;
      int unsigned n;
      logic [3:0]  idx;
      logic [3:0]  regsel;
      logic [32:0] seg_end;
      logic [15:0] use_mask;
      logic [15:0] full_vec;
      bit          data_read;
      bit          status_read;
      r           = '0;
      r.ack       = mtbt_pkg::ACK_NONE;
      n           = terms_used();
      idx         = it.address[7:4];
      regsel      = it.address[3:0] & mtbt_pkg::REG_MASK;
      seg_end     = {1'b0, seg_base} + {1'b0, seg_size};
      data_read   = 1'b0;
      status_read = 1'b0;
      if (it.bus_select) begin
        if (it.address < seg_base || {1'b0, it.address} >= seg_end || idx >= n) begin
          r.ack = mtbt_pkg::ACK_ERROR;
        end else if (regsel == mtbt_pkg::WRITE_OFFSET && !it.is_read) begin
          r.ack              = mtbt_pkg::ACK_READY;
          r.display_valid    = 1'b1;
          r.display_terminal = idx;
          r.display_char     = it.write_data[7:0];
        end else if (regsel == mtbt_pkg::STATUS_OFFSET && it.is_read) begin
          r.ack       = mtbt_pkg::ACK_READY;
          status_read = 1'b1;
        end else if (regsel == mtbt_pkg::READ_OFFSET && it.is_read) begin
          r.ack         = mtbt_pkg::ACK_READY;
          data_read     = 1'b1;
          r.read_data   = kbd_char[idx];
          kbd_full[idx] = 1'b0;
        end else if (regsel == mtbt_pkg::CONFIG_OFFSET && !it.is_read) begin
          r.ack = mtbt_pkg::ACK_READY;
        end else begin
          r.ack = mtbt_pkg::ACK_ERROR;
        end
      end
      if (it.key_valid && it.key_terminal < n && !kbd_full[it.key_terminal] && !data_read)
      begin
        r.key_taken = 1'b1;
        // carriage return is swallowed: the buffer stays empty
        if (it.key_char != mtbt_pkg::CHAR_CR) begin
          kbd_full[it.key_terminal] = 1'b1;
          kbd_char[it.key_terminal] = it.key_char;
        end
      end
      if (status_read) r.read_data = {7'b0, kbd_full[idx]};
      use_mask = (n >= 16) ? 16'hFFFF : ((16'h1 << n) - 16'h1);
      for (int i = 0; i < 16; i++) full_vec[i] = kbd_full[i];
      r.irq_keyboard = full_vec & kbd_irq_en & use_mask;
      r.irq_display  = dsp_irq_en & use_mask;
      return r;
    endfunction

    function void note_input(bus_item_t it);
      response_q.push_back(decode_access(it));
    endfunction

    function int unsigned pending();
      return response_q.size();
    endfunction

    task report(string msg);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, msg);
    endtask

    task check_result(bus_result_t got);
      bus_result_t want;
      if (response_q.size() == 0) begin
        report("result item with no bus item outstanding");
        return;
      end
      want = response_q.pop_front();
      if (got.ack !== want.ack)
        report($sformatf("ack %0d, model %0d", got.ack, want.ack));
      if (got.read_data !== want.read_data)
        report($sformatf("read_data %h, model %h", got.read_data, want.read_data));
      if (got.display_valid !== want.display_valid)
        report($sformatf("display_valid %b, model %b", got.display_valid, want.display_valid));
      if (got.display_terminal !== want.display_terminal)
        report($sformatf("display_terminal %h, model %h", got.display_terminal,
                         want.display_terminal));
      if (got.display_char !== want.display_char)
        report($sformatf("display_char %h, model %h", got.display_char, want.display_char));
      if (got.key_taken !== want.key_taken)
        report($sformatf("key_taken %b, model %b", got.key_taken, want.key_taken));
      if (got.irq_keyboard !== want.irq_keyboard)
        report($sformatf("irq_keyboard %h, model %h", got.irq_keyboard, want.irq_keyboard));
      if (got.irq_display !== want.irq_display)
        report($sformatf("irq_display %h, model %h", got.irq_display, want.irq_display));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  mtbt_in_if  in_ch ();
  mtbt_out_if out_ch ();

  multi_terminal_bus_target dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .in_i    (in_ch),
    .out_o   (out_ch)
  );

  term_scoreboard sb = new();

  int unsigned sender_idle_pct = 0;
  int unsigned recv_idle_pct   = 0;
  int unsigned rand_sent       = 0;
  int unsigned cycle_count     = 0;
  bit          hold_go         = 1'b0;
  bit          holding         = 1'b0;

  always begin
    clk_i = 1'b0;
    #HALF_PERIOD;
    clk_i = 1'b1;
    #HALF_PERIOD;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Long receiver hold-off, so the block fills and stalls its input
  initial begin : hold_ctrl
    wait (hold_go);
    @(posedge clk_i);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin : result_rx
    bus_result_t got;
    if (rst_ni && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.ack              = mtbt_pkg::ack_e'(out_ch.ack);
      got.read_data        = out_ch.read_data;
      got.display_valid    = out_ch.display_valid;
      got.display_terminal = out_ch.display_terminal;
      got.display_char     = out_ch.display_char;
      got.key_taken        = out_ch.key_taken;
      got.irq_keyboard     = out_ch.irq_keyboard;
      got.irq_display      = out_ch.irq_display;
      sb.check_result(got);
    end
    out_ch.ready <= !holding && ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic bus_item_t mk(bit sel, logic [31:0] a, bit rd, logic [31:0] wd,
                                   bit kv, logic [3:0] kt, logic [7:0] kc);
    bus_item_t it;
    it.bus_select   = sel;
    it.address      = a;
    it.is_read      = rd;
    it.write_data   = wd;
    it.key_valid    = kv;
    it.key_terminal = kt;
    it.key_char     = kc;
    return it;
  endfunction

  function automatic logic [31:0] pick_address();
    int unsigned roll;
    logic [32:0] room;
    logic [31:0] lim;
    logic [31:0] seg_end;
    roll    = $urandom_range(99);
    room    = 33'h1_0000_0000 - {1'b0, sb.seg_base};
    lim     = (sb.seg_size > 32'd512) ? 32'd512 : sb.seg_size;
    if ({1'b0, lim} > room) lim = room[31:0];
    seg_end = sb.seg_base + sb.seg_size;
    if (roll < 75) return sb.seg_base + ($urandom % lim);
    if (roll < 90) begin
      // straddle one rim of the segment
      if ($urandom_range(1)) return sb.seg_base - 32'($urandom_range(16, 1));
      return seg_end + 32'($urandom_range(16)) - 32'd8;
    end
    return $urandom;
  endfunction

  function automatic bus_item_t rand_item();
    bus_item_t   it;
    logic [3:0]  regsel;
    int unsigned n;
    n               = sb.terms_used();
    it.bus_select   = ($urandom_range(99) < 85);
    it.address      = pick_address();
    case ($urandom_range(3))
      0:       regsel = mtbt_pkg::WRITE_OFFSET;
      1:       regsel = mtbt_pkg::STATUS_OFFSET;
      2:       regsel = mtbt_pkg::READ_OFFSET;
      default: regsel = mtbt_pkg::CONFIG_OFFSET;
    endcase
    it.address[3:2] = regsel[3:2];
    if ($urandom_range(99) < 80)
      it.is_read = (regsel == mtbt_pkg::STATUS_OFFSET || regsel == mtbt_pkg::READ_OFFSET);
    else
      it.is_read = 1'($urandom_range(1));
    it.write_data   = $urandom;
    it.key_valid    = ($urandom_range(99) < 55);
    if (n > 0 && $urandom_range(99) < 80) it.key_terminal = 4'($urandom_range(n - 1));
    else it.key_terminal = 4'($urandom_range(15));
    it.key_char     = ($urandom_range(99) < 15) ? mtbt_pkg::CHAR_CR
                                                : 8'($urandom_range(255));
    return it;
  endfunction

  // Valid stays high across back-to-back items; drop it only for a gap
  task automatic send_item(bus_item_t it);
    if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.bus_select   <= it.bus_select;
    in_ch.address      <= it.address;
    in_ch.is_read      <= it.is_read;
    in_ch.write_data   <= it.write_data;
    in_ch.key_valid    <= it.key_valid;
    in_ch.key_terminal <= it.key_terminal;
    in_ch.key_char     <= it.key_char;
    do @(posedge clk_i); while (in_ch.ready !== 1'b1);
    sb.note_input(it);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic apb_write(mtbt_pkg::cfg_reg_e r, logic [31:0] v);
    logic [31:0] rd;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= v;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.write_reg(r, v);
    // read the register back
    @(posedge clk_i);
    psel    <= 1'b1;
    paddr   <= {r, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd !== sb.reg_value(r))
      sb.report($sformatf("register %s reads %h, written %h", r.name(), rd, sb.reg_value(r)));
  endtask

  task automatic configure(logic [31:0] base, logic [31:0] size, logic [4:0] count,
                           logic [15:0] kbd_en, logic [15:0] dsp_en);
    drain();
    apb_write(mtbt_pkg::CFG_SEG_BASE, base);
    apb_write(mtbt_pkg::CFG_SEG_SIZE, size);
    apb_write(mtbt_pkg::CFG_TERM_COUNT, {27'b0, count});
    apb_write(mtbt_pkg::CFG_KBD_IRQ_EN, {16'b0, kbd_en});
    apb_write(mtbt_pkg::CFG_DSP_IRQ_EN, {16'b0, dsp_en});
    @(posedge clk_i);
  endtask

  task automatic run_random(int unsigned count);
    for (int unsigned k = 0; k < count; k++) begin
      if (rand_sent < 517) begin
        sender_idle_pct = 20;
        recv_idle_pct   = 80;
      end else if (rand_sent < 1034) begin
        sender_idle_pct = 80;
        recv_idle_pct   = 20;
      end else begin
        sender_idle_pct = 0;
        recv_idle_pct   = 0;
      end
      send_item(rand_item());
      rand_sent++;
    end
  endtask

  initial begin : stimulus
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.bus_select   = 1'b0;
    in_ch.address      = '0;
    in_ch.is_read      = 1'b0;
    in_ch.write_data   = '0;
    in_ch.key_valid    = 1'b0;
    in_ch.key_terminal = '0;
    in_ch.key_char     = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part on the reset configuration
    sender_idle_pct = 20;
    recv_idle_pct   = 50;
    send_item(mk(0, 32'hFFFF_FFFF, 1, 32'hFFFF_FFFF, 0, 4'hF, 8'hFF)); // bus idle
    send_item(mk(1, 32'h0000_0000, 0, 32'h0000_0041, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_00F0, 0, 32'hFFFF_FFFF, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_000C, 0, 32'h1234_5678, 1, 4'h0, 8'h41)); // key fills term 0
    send_item(mk(1, 32'h0000_0004, 1, 32'h0, 1, 4'h0, 8'h42));        // full: not taken
    send_item(mk(1, 32'h0000_0008, 1, 32'h0, 1, 4'h1, 8'h43));        // data read blocks key
    send_item(mk(1, 32'h0000_0004, 1, 32'h0, 1, 4'h2, mtbt_pkg::CHAR_CR));
    send_item(mk(1, 32'h0000_0024, 1, 32'h0, 0, 4'h2, 8'h00));
    send_item(mk(0, 32'h0, 0, 32'h0, 1, 4'hF, 8'hFF));
    send_item(mk(0, 32'h0, 0, 32'h0, 1, 4'hE, 8'h00));
    send_item(mk(1, 32'h0000_00F8, 1, 32'h0, 1, 4'hE, 8'h11));
    send_item(mk(1, 32'h0000_00E8, 1, 32'h0, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_0038, 1, 32'h0, 0, 4'h0, 8'h00));        // empty buffer
    send_item(mk(1, 32'h0000_0000, 1, 32'h0, 0, 4'h0, 8'h00));        // wrong direction
    send_item(mk(1, 32'h0000_0004, 0, 32'h0, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_0008, 0, 32'h0, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_000C, 1, 32'h0, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_0100, 0, 32'h0, 0, 4'h0, 8'h00));        // segment end
    send_item(mk(1, 32'hFFFF_FFFF, 1, 32'h0, 1, 4'h5, 8'h7F));
    send_item(mk(1, 32'h0000_0057, 1, 32'h0, 0, 4'h0, 8'h00));        // low bits ignored

    // No terminals in use
    configure(32'h0, 32'h100, 5'd0, 16'hFFFF, 16'hFFFF);
    send_item(mk(1, 32'h0000_0000, 0, 32'h55, 0, 4'h0, 8'h00));
    send_item(mk(0, 32'h0, 0, 32'h0, 1, 4'h0, 8'h33));
    // Count above the terminal limit
    configure(32'h0, 32'h100, 5'd31, 16'hFFFF, 16'hFFFF);
    send_item(mk(1, 32'h0000_00F4, 1, 32'h0, 0, 4'h0, 8'h00));
    send_item(mk(0, 32'h0, 0, 32'h0, 1, 4'h9, 8'h55));
    // Terminal index beyond the count
    configure(32'h0, 32'h100, 5'd4, 16'hFFFF, 16'hFFFF);
    send_item(mk(1, 32'h0000_0040, 0, 32'h66, 0, 4'h0, 8'h00));
    send_item(mk(1, 32'h0000_0034, 1, 32'h0, 1, 4'h4, 8'h77));

    // Random part
    configure(mtbt_pkg::SEG_BASE_RST, mtbt_pkg::SEG_SIZE_RST, mtbt_pkg::TERM_COUNT_RST,
              mtbt_pkg::KBD_IRQ_EN_RST, mtbt_pkg::DSP_IRQ_EN_RST);
    hold_go = 1'b1;
    run_random(300);
    configure(32'hFFFF_FFF0, 32'hFFFF_FFFF, 5'd16, 16'($urandom), 16'hFFFF);
    run_random(200);
    configure($urandom & 32'hFFFF_FFF0, 32'd16, 5'd16, 16'($urandom), 16'($urandom));
    run_random(150);
    configure(32'h0000_1000, 32'd16 + ($urandom % 1009), 5'd1, 16'($urandom),
              16'($urandom));
    run_random(250);
    configure($urandom & 32'h000F_FFF0, 32'h100, 5'($urandom_range(16, 1)),
              16'($urandom), 16'($urandom));
    run_random(350);
    configure(32'h0, 32'h200, 5'($urandom_range(15, 2)), 16'h0000, 16'hFFFF);
    run_random(300);

    drain();
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/core/mtbt_pkg.sv
rtl/core/mtbt_if.sv
rtl/core/mtbt_decode.sv
rtl/core/mtbt_kbd.sv
rtl/core/multi_terminal_bus_target.sv
tb/multi_terminal_bus_target_tb.sv
